FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/htfd_pkg.sv
// ---------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 step for the humidity/temperature decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package htfd_pkg;

   // CRC-8, polynomial 0x31, init 0xFF, MSB first, no final xor
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Byte positions inside a reply frame
   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_MSB  = 3'd3;
   localparam logic [2:0] POS_HUM_LSB  = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;
   localparam logic [2:0] FRAME_LEN    = 3'd6;

   // Scaling constants: value = floor(span * raw / 65535), less TEMP_OFFSET for temperature
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [16:0] WORD_MAX    = 17'd65535;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_CRC = 2'd1,
      STATUS_HUM_CRC  = 2'd2
   } status_type;

   // One completed frame handed from the byte tracker to the scaler
   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [15:0] raw_humidity;
      status_type  status;
   } frame_type;

   // One byte of CRC-8 (0x31), bitwise MSB first
   function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

FILE: design/htfd_frame.sv
// ---------------------------------------------------------------------------
// htfd_frame
// Tracks the byte position, runs the CRC-8 per word, assembles the raw words
// and registers one frame after the sixth byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htfd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          rx_byte,
   input  logic                frame_start,
   output logic                out_valid,
   input  logic                out_ready,
   output htfd_pkg::frame_type out_frame
);

   logic [2:0]          pos_ff, pos_in;
   logic [7:0]          crc_ff, crc_in;
   logic [15:0]         temp_ff, temp_in;
   logic [15:0]         hum_ff, hum_in;
   logic                bad_ff, bad_in;
   logic                valid_ff, valid_in;
   htfd_pkg::frame_type frame_ff, frame_in;

   logic       accept;
   logic       restart;
   logic       emit;
   logic [2:0] pos_cur;
   logic [7:0] crc_cur;
   logic [7:0] crc_next;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // Per-byte state update
   always_comb begin
      restart  = frame_start || (pos_ff >= htfd_pkg::FRAME_LEN);
      pos_cur  = restart ? htfd_pkg::POS_TEMP_MSB : pos_ff;
      crc_cur  = restart ? htfd_pkg::CRC_INIT : crc_ff;
      crc_next = htfd_pkg::crc8_step(crc_cur, rx_byte);
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      temp_in  = temp_ff;
      hum_in   = hum_ff;
      bad_in   = bad_ff;
      emit     = 1'b0;
      if (accept) begin
         pos_in = pos_cur + 3'd1;
         case (pos_cur)
            htfd_pkg::POS_TEMP_MSB: begin
               temp_in = {rx_byte, temp_ff[7:0]};
               crc_in  = crc_next;
            end
            htfd_pkg::POS_TEMP_LSB: begin
               temp_in = {temp_ff[15:8], rx_byte};
               crc_in  = crc_next;
            end
            htfd_pkg::POS_TEMP_CRC: begin
               bad_in = (crc_cur != rx_byte);
               crc_in = htfd_pkg::CRC_INIT;
            end
            htfd_pkg::POS_HUM_MSB: begin
               hum_in = {rx_byte, hum_ff[7:0]};
               crc_in = crc_next;
            end
            htfd_pkg::POS_HUM_LSB: begin
               hum_in = {hum_ff[15:8], rx_byte};
               crc_in = crc_next;
            end
            default: begin
               // humidity CRC byte closes the frame
               emit   = 1'b1;
               crc_in = htfd_pkg::CRC_INIT;
               bad_in = 1'b0;
               pos_in = htfd_pkg::POS_TEMP_MSB;
            end
         endcase
      end
   end

   // Completed frame; temperature error wins over humidity error
   always_comb begin
      frame_in.raw_temperature = temp_ff;
      frame_in.raw_humidity    = hum_ff;
      if (bad_ff) begin
         frame_in.status = htfd_pkg::STATUS_TEMP_CRC;
      end else if (crc_cur != rx_byte) begin
         frame_in.status = htfd_pkg::STATUS_HUM_CRC;
      end else begin
         frame_in.status = htfd_pkg::STATUS_OK;
      end
      valid_in = in_ready ? (accept && emit) : valid_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= htfd_pkg::POS_TEMP_MSB;
         crc_ff   <= htfd_pkg::CRC_INIT;
         temp_ff  <= '0;
         hum_ff   <= '0;
         bad_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         temp_ff  <= temp_in;
         hum_ff   <= hum_in;
         bad_ff   <= bad_in;
         valid_ff <= valid_in;
      end
   end

   // Frame payload
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         frame_ff <= frame_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_frame = frame_ff;

endmodule

FILE: design/htfd_scale.sv
// ---------------------------------------------------------------------------
// htfd_scale
// Converts raw words to hundredths: one constant multiply per field, then a
// divide by 65535 done as high half plus one compare-and-correct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module htfd_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  htfd_pkg::frame_type in_frame,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [14:0]  temperature_centi,
   output logic [13:0]         humidity_centi,
   output logic [15:0]         raw_temperature,
   output logic [15:0]         raw_humidity,
   output logic [1:0]          frame_status
);

   // Product stage
   logic                a_valid_ff;
   logic [30:0]         t_prod_ff, t_prod_in;
   logic [29:0]         h_prod_ff, h_prod_in;
   htfd_pkg::frame_type a_frame_ff;
   logic                a_ready;

   // Result stage
   logic                b_valid_ff, b_valid_in;
   logic                b_ready;
   logic signed [14:0]  temp_ff, temp_in;
   logic [13:0]         hum_ff, hum_in;
   htfd_pkg::frame_type b_frame_ff;

   logic [14:0] t_hi, t_quo;
   logic [15:0] t_lo, h_lo;
   logic [16:0] t_sum, h_sum;
   logic [13:0] h_hi, h_quo;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Constant multiplies
   assign t_prod_in = 31'(htfd_pkg::TEMP_SPAN) * 31'(in_frame.raw_temperature);
   assign h_prod_in = 30'(htfd_pkg::HUM_SPAN) * 30'(in_frame.raw_humidity);

   // x / 65535 with x = hi*65536 + lo: hi + (hi + lo >= 65535)
   always_comb begin
      t_hi  = t_prod_ff[30:16];
      t_lo  = t_prod_ff[15:0];
      t_sum = 17'(t_hi) + 17'(t_lo);
      t_quo = t_hi + 15'(t_sum >= htfd_pkg::WORD_MAX);
      temp_in = signed'(t_quo - htfd_pkg::TEMP_OFFSET);
      h_hi  = h_prod_ff[29:16];
      h_lo  = h_prod_ff[15:0];
      h_sum = 17'(h_hi) + 17'(h_lo);
      h_quo = h_hi + 14'(h_sum >= htfd_pkg::WORD_MAX);
      hum_in = h_quo;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         b_valid_ff <= b_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         t_prod_ff  <= t_prod_in;
         h_prod_ff  <= h_prod_in;
         a_frame_ff <= in_frame;
      end
      if (b_ready && a_valid_ff) begin
         temp_ff    <= temp_in;
         hum_ff     <= hum_in;
         b_frame_ff <= a_frame_ff;
      end
   end

   assign out_valid         = b_valid_ff;
   assign temperature_centi = temp_ff;
   assign humidity_centi    = hum_ff;
   assign raw_temperature   = b_frame_ff.raw_temperature;
   assign raw_humidity      = b_frame_ff.raw_humidity;
   assign frame_status      = b_frame_ff.status;

endmodule

FILE: design/humidity_temp_frame_decode.sv
// ---------------------------------------------------------------------------
// humidity_temp_frame_decode
// Decodes a six-byte humidity/temperature sensor reply with CRC-8 checks and
// scales both words to hundredths.
//
//   channel | direction | transaction
//   req_    | in        | one reply byte plus frame start flag
//   rsp_    | out       | scaled and raw values plus status, once per frame
//
// One byte is accepted every cycle while req_ready is high; CRC and position
// update in one pass. After the sixth byte the result passes through the
// frame register, the product register and the result register.
// Reset (synchronous) clears the position, CRC and all valid flags.
// A stalled rsp_ side backs up through the three registers before req_ready
// drops; with rsp_valid low, req_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module humidity_temp_frame_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [15:0]        rsp_raw_temperature,
   output logic [15:0]        rsp_raw_humidity,
   output logic [1:0]         rsp_frame_status
);

   logic                frame_valid;
   logic                frame_ready;
   htfd_pkg::frame_type frame;

   // Byte tracking and CRC
   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .out_valid   (frame_valid),
      .out_ready   (frame_ready),
      .out_frame   (frame)
   );

   // Scaling to hundredths
   htfd_scale u_scale (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (frame_valid),
      .in_ready          (frame_ready),
      .in_frame          (frame),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .temperature_centi (rsp_temperature_centi),
      .humidity_centi    (rsp_humidity_centi),
      .raw_temperature   (rsp_raw_temperature),
      .raw_humidity      (rsp_raw_humidity),
      .frame_status      (rsp_frame_status)
   );

endmodule

FILE: design/htfd_checker.sv
// ---------------------------------------------------------------------------
// htfd_checker
// Port-level checks for the humidity/temperature frame decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_rx_byte,
   input logic               req_frame_start,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [14:0] rsp_temperature_centi,
   input logic [13:0]        rsp_humidity_centi,
   input logic [15:0]        rsp_raw_temperature,
   input logic [15:0]        rsp_raw_humidity,
   input logic [1:0]         rsp_frame_status
);

   // Stalled result keeps rsp_valid high and holds its raw words and status
   `ASSERT_SYNC(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_temperature) && $stable(rsp_raw_humidity) && $stable(rsp_frame_status), "rsp transaction changed while stalled")

   // Scaled values stay in range
   `ASSERT_SYNC(a_scale_range, clock, reset, rsp_valid |-> rsp_temperature_centi >= -15'sd4500 && rsp_temperature_centi <= 15'sd13000 && rsp_humidity_centi <= 14'd10000, "scaled value out of range")

   // Full-scale humidity word maps to exactly 100.00 percent
   `ASSERT_SYNC(a_hum_full, clock, reset, rsp_valid && rsp_raw_humidity == 16'hFFFF |-> rsp_humidity_centi == 14'd10000, "full-scale humidity mis-scaled")

   // Empty output side never blocks input
   `ASSERT_SYNC(a_ready_free, clock, reset, !rsp_valid |-> req_ready, "req_ready low with empty output")

   // Nothing comes out right after reset
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "rsp_valid high after reset")

endmodule

bind humidity_temp_frame_decode htfd_checker u_checker (.*);

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: humidity/temperature frame decoder testbench
// Feeds six-byte sensor replies, one byte per transaction, into the decoder
// and predicts each frame result. The prediction covers the CRC-8 check, the
// raw words, the scaled values and the status. Every result transaction is
// compared field by field against the oldest predicted reading. The run has
// a few directed frames first, then random frames, truncated frames and
// noise bytes. Both sides stall at random except in the last random pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_BYTES = 1250;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;

   // One decoded frame as it should leave the block
   typedef struct {
      logic signed [14:0]   temp_centi;
      logic [13:0]          hum_centi;
      logic [15:0]          temp_raw;
      logic [15:0]          hum_raw;
      htfd_pkg::status_type status;
   } reading_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               req_frame_start;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;
   logic [15:0]        rsp_raw_temperature;
   logic [15:0]        rsp_raw_humidity;
   logic [1:0]         rsp_frame_status;

   reading_type pending_readings[$];
   int          mismatch_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          stall_cycles;

   // Decoder state as the testbench tracks it
   logic [2:0]  dec_pos;
   logic [7:0]  dec_crc;
   logic [15:0] dec_temp;
   logic [15:0] dec_hum;
   logic        dec_temp_bad;

   humidity_temp_frame_decode uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .req_frame_start       (req_frame_start),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_raw_temperature   (rsp_raw_temperature),
      .rsp_raw_humidity      (rsp_raw_humidity),
      .rsp_frame_status      (rsp_frame_status)
   );

   always #(CLK_HALF) clock = ~clock;

   // CRC-8, polynomial 0x31, MSB first
   function automatic logic [7:0] crc8_0x31(logic [7:0] crc, logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {r[6:0], 1'b0};
      return r;
   endfunction

   // Advance the tracked decoder by one byte; queue a reading on the sixth
   task automatic decode_byte(input logic [7:0] b, input logic start);
      logic [2:0]  p;
      int unsigned t_scaled;
      int unsigned h_scaled;
      reading_type r;
      p = dec_pos;
      if (start || p >= htfd_pkg::FRAME_LEN) begin
         p = htfd_pkg::POS_TEMP_MSB;
         dec_crc = htfd_pkg::CRC_INIT;
      end
      case (p)
         htfd_pkg::POS_TEMP_MSB: begin
            dec_temp[15:8] = b;
            dec_crc = crc8_0x31(dec_crc, b);
         end
         htfd_pkg::POS_TEMP_LSB: begin
            dec_temp[7:0] = b;
            dec_crc = crc8_0x31(dec_crc, b);
         end
         htfd_pkg::POS_TEMP_CRC: begin
            dec_temp_bad = (dec_crc != b);
            dec_crc = htfd_pkg::CRC_INIT;
         end
         htfd_pkg::POS_HUM_MSB: begin
            dec_hum[15:8] = b;
            dec_crc = crc8_0x31(dec_crc, b);
         end
         htfd_pkg::POS_HUM_LSB: begin
            dec_hum[7:0] = b;
            dec_crc = crc8_0x31(dec_crc, b);
         end
         htfd_pkg::POS_HUM_CRC: begin
            t_scaled = (32'(htfd_pkg::TEMP_SPAN) * 32'(dec_temp))
                       / 32'(htfd_pkg::WORD_MAX);
            h_scaled = (32'(htfd_pkg::HUM_SPAN) * 32'(dec_hum))
                       / 32'(htfd_pkg::WORD_MAX);
            r.temp_centi = 15'(int'(t_scaled) - int'(htfd_pkg::TEMP_OFFSET));
            r.hum_centi  = 14'(h_scaled);
            r.temp_raw   = dec_temp;
            r.hum_raw    = dec_hum;
            // temperature error wins over humidity error
            if (dec_temp_bad) r.status = htfd_pkg::STATUS_TEMP_CRC;
            else if (dec_crc != b) r.status = htfd_pkg::STATUS_HUM_CRC;
            else r.status = htfd_pkg::STATUS_OK;
            pending_readings.push_back(r);
            dec_crc = htfd_pkg::CRC_INIT;
            dec_temp_bad = 1'b0;
         end
         default: ;
      endcase
      dec_pos = (p == htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_MSB : p + 3'd1;
   endtask

   // Track every accepted byte transaction
   always @(posedge clock) begin
      if (reset) begin
         dec_pos = htfd_pkg::POS_TEMP_MSB;
         dec_crc = htfd_pkg::CRC_INIT;
         dec_temp = '0;
         dec_hum = '0;
         dec_temp_bad = 1'b0;
      end else if (req_valid && req_ready) begin
         decode_byte(req_rx_byte, req_frame_start);
      end
   end

   // Compare each result transaction with the oldest predicted reading
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $error("result transaction with no reading pending (raw_temperature %h)",
                   rsp_raw_temperature);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_temperature_centi !== want.temp_centi) begin
               $error("temperature_centi: expected %0d, got %0d",
                      want.temp_centi, rsp_temperature_centi);
               mismatch_count++;
            end
            if (rsp_humidity_centi !== want.hum_centi) begin
               $error("humidity_centi: expected %0d, got %0d",
                      want.hum_centi, rsp_humidity_centi);
               mismatch_count++;
            end
            if (rsp_raw_temperature !== want.temp_raw) begin
               $error("raw_temperature: expected %h, got %h",
                      want.temp_raw, rsp_raw_temperature);
               mismatch_count++;
            end
            if (rsp_raw_humidity !== want.hum_raw) begin
               $error("raw_humidity: expected %h, got %h",
                      want.hum_raw, rsp_raw_humidity);
               mismatch_count++;
            end
            if (rsp_frame_status !== want.status) begin
               $error("frame_status: expected %s, got %0d",
                      want.status.name(), rsp_frame_status);
               mismatch_count++;
            end
         end
      end
   end

   // Receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Watchdog: too long with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Send one byte transaction; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic start);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Send a full reply; a bad CRC is the good one with some bits flipped
   task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                             input bit t_ok, input bit h_ok, input bit start);
      logic [7:0] t_crc;
      logic [7:0] h_crc;
      t_crc = crc8_0x31(crc8_0x31(htfd_pkg::CRC_INIT, t_word[15:8]), t_word[7:0]);
      h_crc = crc8_0x31(crc8_0x31(htfd_pkg::CRC_INIT, h_word[15:8]), h_word[7:0]);
      if (!t_ok) t_crc ^= 8'($urandom_range(255, 1));
      if (!h_ok) h_crc ^= 8'($urandom_range(255, 1));
      send_byte(t_word[15:8], start);
      send_byte(t_word[7:0], 1'b0);
      send_byte(t_crc, 1'b0);
      send_byte(h_word[15:8], 1'b0);
      send_byte(h_word[7:0], 1'b0);
      send_byte(h_crc, 1'b0);
   endtask

   // Mostly uniform words, sometimes all zeros or all ones
   function automatic logic [15:0] random_word();
      if ($urandom_range(7, 0) == 0) return {16{1'($urandom_range(1, 0))}};
      return 16'($urandom);
   endfunction

   // Scale extremes; the second frame has no start flag and both CRCs wrong
   task automatic test_word_extremes();
      send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_temp_crc_error();
      send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);
   endtask

   // Abandon a frame after two bytes; the start flag realigns
   task automatic test_frame_restart();
      send_byte(8'h5A, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_frame(16'h0001, 16'hFFFE, 1'b1, 1'b0, 1'b1);
   endtask

   // Mostly well-formed frames, some truncated frames and some noise
   task automatic test_random_traffic(input int n_bytes, input int send_pct,
                                      input int recv_pct);
      int sent;
      int pick;
      int k;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(99, 0);
         if (pick < 75) begin
            send_frame(random_word(), random_word(), $urandom_range(99, 0) < 85,
                       $urandom_range(99, 0) < 85, $urandom_range(9, 0) != 0);
            sent += 6;
         end else if (pick < 88) begin
            k = $urandom_range(5, 1);
            send_byte(8'($urandom), 1'b1);
            for (int i = 1; i < k; i++) send_byte(8'($urandom), 1'b0);
            sent += k;
         end else begin
            send_byte(8'($urandom), 1'($urandom_range(1, 0)));
            sent += 1;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      req_frame_start = 1'b0;
      rsp_ready = 1'b0;
      mismatch_count = 0;
      send_idle_pct = 15;
      recv_idle_pct = 53;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_word_extremes();
      test_temp_crc_error();
      test_frame_restart();
      test_random_traffic(RANDOM_BYTES / 3, 15, 53);
      test_random_traffic(RANDOM_BYTES / 3, 53, 15);
      test_random_traffic(RANDOM_BYTES / 3, 0, 0);
      req_valid <= 1'b0;

      // drain outstanding readings, then let the pipeline settle
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/htfd_pkg.sv
design/htfd_frame.sv
design/htfd_scale.sv
design/humidity_temp_frame_decode.sv
design/htfd_checker.sv
tb/sv/tb_top.sv
